// ===== rtl/tbe_pkg.sv =====
// shared types and constants for the task budget enforcer
// no dependencies; used by every module of the block by scoped names
package tbe_pkg;

    localparam int unsigned BUDGET_W = 40;
    localparam int unsigned THRESH_W = 20;
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 40;
    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 440;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 20'd5000;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_BUDGET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENFORCE_ENABLE = 2'd2;

    typedef enum logic [2:0] {
        OP_FIRST_JOB    = 3'd0,
        OP_NEXT_JOB     = 3'd1,
        OP_NEXT_JOB_ALT = 3'd2,
        OP_SWITCH_IN    = 3'd3,
        OP_SWITCH_OUT   = 3'd4,
        OP_TICK         = 3'd5,
        OP_REFRESH      = 3'd6,
        OP_QUERY        = 3'd7
    } op_t;

    typedef struct packed {
        logic [BUDGET_W-1:0] period_budget;
        logic [THRESH_W-1:0] throttle_threshold;
        logic                enforce_enable;
    } cfg_t;

    typedef struct packed {
        logic [BUDGET_W-1:0] remaining_budget;
        logic [TIME_W-1:0]   job_runtime;
        logic [TIME_W-1:0]   job_runtime_alt;
        logic [TIME_W-1:0]   period_used;
        logic                throttled;
        logic                resched_request;
        logic                wake_request;
        logic                timer_arm;
        logic [BUDGET_W-1:0] timer_delay;
        logic [COUNT_W-1:0]  overrun_count;
        logic [TIME_W-1:0]   max_overuse;
        logic [TIME_W-1:0]   consumed_total;
    } result_t;

endpackage

// ===== rtl/tbe_cfg_regs.sv =====
// configuration registers of the task budget enforcer
// depends on tbe_pkg for the register indexes and the cfg_t type
module tbe_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tbe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tbe_pkg::CFG_DATA_W-1:0]    cfg_data,
    output tbe_pkg::cfg_t                     cfg
);

    tbe_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_budget      <= '0;
            cfg_reg.throttle_threshold <= tbe_pkg::THRESHOLD_RESET;
            cfg_reg.enforce_enable     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbe_pkg::CFG_PERIOD_BUDGET:
                    cfg_reg.period_budget <= cfg_data;
                tbe_pkg::CFG_THROTTLE_THR:
                    cfg_reg.throttle_threshold <= cfg_data[tbe_pkg::THRESH_W-1:0];
                tbe_pkg::CFG_ENFORCE_ENABLE:
                    cfg_reg.enforce_enable <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/tbe_core.sv =====
// task state registers and the single-pass event update
// depends on tbe_pkg for op_t, cfg_t and result_t
module tbe_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  tbe_pkg::op_t                  op,
    input  logic [tbe_pkg::TIME_W-1:0]    now,
    input  logic                          queue_nonempty,
    input  tbe_pkg::cfg_t                 cfg,
    output tbe_pkg::result_t              res
);

    localparam int unsigned TW = tbe_pkg::TIME_W;
    localparam int unsigned BW = tbe_pkg::BUDGET_W;
    localparam int unsigned HW = tbe_pkg::THRESH_W;
    localparam int unsigned CW = tbe_pkg::COUNT_W;

    logic          sleeping_reg, sleeping_next;
    logic          throttle_reg, throttle_next;
    logic [TW-1:0] period_start_reg, period_start_next;
    logic [TW-1:0] job_start_reg, job_start_next;
    logic [TW-1:0] job_start_alt_reg, job_start_alt_next;
    logic [TW-1:0] job_accum_reg, job_accum_next;
    logic [TW-1:0] job_accum_alt_reg, job_accum_alt_next;
    logic [TW-1:0] period_accum_reg, period_accum_next;
    logic [CW-1:0] overuse_cnt_reg, overuse_cnt_next;
    logic [TW-1:0] overuse_peak_reg, overuse_peak_next;
    logic [TW-1:0] consumed_reg, consumed_next;

    logic [TW-1:0] d_period, d_job, d_alt;
    logic [TW-1:0] since_period, since_job, since_alt;
    logic [TW-1:0] used_before, used_after;
    logic [TW-1:0] budget_ext, thresh_ext, over;
    logic [BW-1:0] rem_diff, rem;
    logic          rem_zero, check;
    logic          resched, wake, arm;
    logic [TW-1:0] job_out, alt_out;

    assign d_period     = now - period_start_reg;
    assign d_job        = now - job_start_reg;
    assign d_alt        = now - job_start_alt_reg;
    assign since_period = sleeping_reg ? '0 : d_period;
    assign since_job    = sleeping_reg ? '0 : d_job;
    assign since_alt    = sleeping_reg ? '0 : d_alt;
    assign used_before  = period_accum_reg + since_period;
    assign budget_ext   = {{(TW-BW){1'b0}}, cfg.period_budget};
    assign thresh_ext   = {{(TW-HW){1'b0}}, cfg.throttle_threshold};
    assign over         = used_before - budget_ext;

    // used after the event, picked per op from the values before it
    always_comb
    begin
        case (op)
            tbe_pkg::OP_FIRST_JOB: used_after = '0;
            tbe_pkg::OP_SWITCH_IN: used_after = throttle_reg ? used_before : period_accum_reg;
            tbe_pkg::OP_REFRESH:   used_after = since_period;
            default:               used_after = used_before;
        endcase
    end

    assign rem_diff = cfg.period_budget - used_after[BW-1:0];
    assign rem      = ((used_after >= budget_ext) ||
                       (rem_diff < {{(BW-HW){1'b0}}, cfg.throttle_threshold})) ? '0 : rem_diff;
    assign rem_zero = (rem == '0);
    assign check    = cfg.enforce_enable &&
                      (((op == tbe_pkg::OP_SWITCH_IN) && !throttle_reg) ||
                       (op == tbe_pkg::OP_TICK));

    always_comb
    begin
        sleeping_next      = sleeping_reg;
        throttle_next      = throttle_reg;
        period_start_next  = period_start_reg;
        job_start_next     = job_start_reg;
        job_start_alt_next = job_start_alt_reg;
        job_accum_next     = job_accum_reg;
        job_accum_alt_next = job_accum_alt_reg;
        period_accum_next  = period_accum_reg;
        overuse_cnt_next   = overuse_cnt_reg;
        overuse_peak_next  = overuse_peak_reg;
        consumed_next      = consumed_reg;
        resched            = 1'b0;
        wake               = 1'b0;
        arm                = 1'b0;

        unique case (op)
            tbe_pkg::OP_FIRST_JOB:
            begin
                job_accum_next     = '0;
                job_accum_alt_next = '0;
                job_start_next     = now;
                job_start_alt_next = now;
                period_accum_next  = '0;
                period_start_next  = now;
            end
            tbe_pkg::OP_NEXT_JOB:
            begin
                job_accum_next = '0;
                job_start_next = now;
            end
            tbe_pkg::OP_NEXT_JOB_ALT:
            begin
                job_accum_alt_next = '0;
                job_start_alt_next = now;
            end
            tbe_pkg::OP_SWITCH_IN:
            begin
                if (throttle_reg)
                begin
                    resched = 1'b1;
                end
                else
                begin
                    period_start_next  = now;
                    job_start_next     = now;
                    job_start_alt_next = now;
                    sleeping_next      = 1'b0;
                end
            end
            tbe_pkg::OP_SWITCH_OUT:
            begin
                if (!sleeping_reg)
                begin
                    job_accum_next     = job_accum_reg + d_job;
                    job_accum_alt_next = job_accum_alt_reg + d_alt;
                    period_accum_next  = used_before;
                    sleeping_next      = 1'b1;
                end
            end
            tbe_pkg::OP_REFRESH:
            begin
                if (used_before > budget_ext)
                begin
                    if ((over > thresh_ext) && (overuse_cnt_reg != '1))
                    begin
                        overuse_cnt_next = overuse_cnt_reg + CW'(1);
                    end
                    if (over > overuse_peak_reg)
                    begin
                        overuse_peak_next = over;
                    end
                end
                consumed_next     = consumed_reg + period_accum_reg;
                period_accum_next = '0;
                throttle_next     = 1'b0;
                wake              = throttle_reg && queue_nonempty;
            end
            default:
                ;
        endcase

        // enabled budget check on tick and unthrottled switch-in
        if (check)
        begin
            if (rem_zero)
            begin
                if (!throttle_reg)
                begin
                    throttle_next = 1'b1;
                    resched       = 1'b1;
                end
            end
            else
            begin
                arm = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (op)
            tbe_pkg::OP_FIRST_JOB: job_out = '0;
            tbe_pkg::OP_NEXT_JOB:  job_out = d_job + job_accum_reg;
            tbe_pkg::OP_SWITCH_IN: job_out = throttle_reg ? job_accum_reg + since_job
                                                          : job_accum_reg;
            default:               job_out = job_accum_reg + since_job;
        endcase
        case (op)
            tbe_pkg::OP_FIRST_JOB:    alt_out = '0;
            tbe_pkg::OP_NEXT_JOB_ALT: alt_out = d_alt + job_accum_alt_reg;
            tbe_pkg::OP_SWITCH_IN:    alt_out = throttle_reg ? job_accum_alt_reg + since_alt
                                                             : job_accum_alt_reg;
            default:                  alt_out = job_accum_alt_reg + since_alt;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleeping_reg      <= 1'b1;
            throttle_reg      <= 1'b0;
            period_start_reg  <= '0;
            job_start_reg     <= '0;
            job_start_alt_reg <= '0;
            job_accum_reg     <= '0;
            job_accum_alt_reg <= '0;
            period_accum_reg  <= '0;
            overuse_cnt_reg   <= '0;
            overuse_peak_reg  <= '0;
            consumed_reg      <= '0;
        end
        else if (step)
        begin
            sleeping_reg      <= sleeping_next;
            throttle_reg      <= throttle_next;
            period_start_reg  <= period_start_next;
            job_start_reg     <= job_start_next;
            job_start_alt_reg <= job_start_alt_next;
            job_accum_reg     <= job_accum_next;
            job_accum_alt_reg <= job_accum_alt_next;
            period_accum_reg  <= period_accum_next;
            overuse_cnt_reg   <= overuse_cnt_next;
            overuse_peak_reg  <= overuse_peak_next;
            consumed_reg      <= consumed_next;
        end
    end

    assign res.remaining_budget = rem;
    assign res.job_runtime      = job_out;
    assign res.job_runtime_alt  = alt_out;
    assign res.period_used      = used_after;
    assign res.throttled        = throttle_next;
    assign res.resched_request  = resched;
    assign res.wake_request     = wake;
    assign res.timer_arm        = arm;
    assign res.timer_delay      = arm ? rem - {{(BW-HW+1){1'b0}}, cfg.throttle_threshold[HW-1:1]}
                                      : '0;
    assign res.overrun_count    = overuse_cnt_next;
    assign res.max_overuse      = overuse_peak_next;
    assign res.consumed_total   = consumed_next;

endmodule

// ===== rtl/task_budget_enforcer_top.sv =====
// top level of the task budget enforcer: input register, core, result register
// depends on tbe_pkg, tbe_cfg_regs and tbe_core
//
//  channel   direction  signals                      payload
//  s_axis    in         tvalid tready tdata tuser    one scheduler event
//  m_axis    out        tvalid tready tdata          one result per event
//  cfg       in         cfg_we cfg_index cfg_data    register write, no handshake
//
// an event is taken into the input register, updated against the task state by the core
// and lands in the result register; one event per cycle sustained while results are accepted
// a result turns valid once its event has passed the input register and the result register
// reset returns the task state and the config registers to their reset values and clears both valid flags
// a stalled result holds while the input register still takes one more event
module task_budget_enforcer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tbe_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // now, queue_nonempty
    input  logic [2:0]                         s_axis_tuser,  // op
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // remaining_budget, job_runtime, job_runtime_alt, period_used, throttled,
    // resched_request, wake_request, timer_arm, timer_delay, overrun_count,
    // max_overuse, consumed_total
    output logic [tbe_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [tbe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned TW = tbe_pkg::TIME_W;

    tbe_pkg::cfg_t    cfg;
    tbe_pkg::result_t res;
    tbe_pkg::result_t out_reg;

    logic             in_valid_reg;
    tbe_pkg::op_t     op_reg;
    logic [TW-1:0]    now_reg;
    logic             qne_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    tbe_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tbe_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .op             (op_reg),
        .now            (now_reg),
        .queue_nonempty (qne_reg),
        .cfg            (cfg),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= tbe_pkg::op_t'(s_axis_tuser);
            now_reg <= s_axis_tdata[TW-1:0];
            qne_reg <= s_axis_tdata[TW];
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0,
                            out_reg.consumed_total,
                            out_reg.max_overuse,
                            out_reg.overrun_count,
                            out_reg.timer_delay,
                            out_reg.timer_arm,
                            out_reg.wake_request,
                            out_reg.resched_request,
                            out_reg.throttled,
                            out_reg.period_used,
                            out_reg.job_runtime_alt,
                            out_reg.job_runtime,
                            out_reg.remaining_budget};

`ifndef SYNTHESIS
    a_arm_not_resched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.timer_arm && out_reg.resched_request))
        else $error("timer armed together with a reschedule request");

    a_wake_unthrottled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.wake_request |-> !out_reg.throttled)
        else $error("wake request while still throttled");

    a_arm_budget_left: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.timer_arm |-> (out_reg.remaining_budget != '0))
        else $error("timer armed with no budget left");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while both stages are full and stalled");
`endif

endmodule
